// File: rtl/pph_pkg.sv
// Shared types, character codes and arithmetic helpers for the P6 header parser.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package pph_pkg;

	localparam int unsigned NUM_BITS = 32;
	localparam int unsigned MAXVAL_BITS = 16;
	localparam int unsigned HDR_LEN_BITS = 16;

	localparam logic [7:0] CHAR_P     = 8'h50;
	localparam logic [7:0] CHAR_SIX   = 8'h36;
	localparam logic [7:0] CHAR_HASH  = 8'h23;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [1:0] FIELD_WIDTH  = 2'd0;
	localparam logic [1:0] FIELD_HEIGHT = 2'd1;
	localparam logic [1:0] FIELD_MAXVAL = 2'd2;
	localparam logic [1:0] FIELD_FULL   = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic                      error;
		logic [NUM_BITS-1:0]       image_width;
		logic [NUM_BITS-1:0]       image_height;
		logic [MAXVAL_BITS-1:0]    max_value;
		logic [HDR_LEN_BITS-1:0]   header_length;
	} hdr_result_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c inside {[CHAR_ZERO:CHAR_NINE]});
	endfunction

	// acc * 10 + digit, saturating at the all-ones value.
	function automatic logic [NUM_BITS-1:0] acc_step(input logic [NUM_BITS-1:0] acc,
			input logic [7:0] c);
		logic [NUM_BITS+3:0] wide;
		logic [7:0]          digit;
		digit = c - CHAR_ZERO;
		wide = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1)
			+ (NUM_BITS+4)'(digit[3:0]);
		return (wide[NUM_BITS+3:NUM_BITS] != 4'b0000) ? {NUM_BITS{1'b1}}
			: wide[NUM_BITS-1:0];
	endfunction

	function automatic logic [MAXVAL_BITS-1:0] sat_maxval(input logic [NUM_BITS-1:0] v);
		return (v[NUM_BITS-1:MAXVAL_BITS] != '0) ? {MAXVAL_BITS{1'b1}}
			: v[MAXVAL_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/pph_byte_if.sv
// Byte stream channel of the P6 header parser: valid/ready plus one file byte
// and its framing marks. No dependencies.
`default_nettype none

interface pph_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink(input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface

`default_nettype wire

// File: rtl/pph_hdr_if.sv
// Result channel of the P6 header parser: valid/ready plus the parsed header.
// No dependencies.
`default_nettype none

interface pph_hdr_if;
	logic        valid;
	logic        ready;
	logic        error;
	logic [31:0] image_width;
	logic [31:0] image_height;
	logic [15:0] max_value;
	logic [15:0] header_length;

	modport source(output valid, output error, output image_width, output image_height,
		output max_value, output header_length, input ready);
	modport sink(input valid, input error, input image_width, input image_height,
		input max_value, input header_length, output ready);
endinterface

`default_nettype wire

// File: rtl/pph_input_stage.sv
// Input register of the P6 header parser: holds one byte until the parser
// consumes it. Depends on pph_pkg.
`default_nettype none

module pph_input_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pph_pkg::byte_item_t in_item,
	input  wire logic               drain,
	output logic                    valid_s1,
	output pph_pkg::byte_item_t     item_s1
);
	import pph_pkg::*;

	logic take;

	// The held byte leaves whenever the downstream side can absorb a result.
	assign in_ready = !valid_s1 || drain;
	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// File: rtl/pph_parser_core.sv
// Parser state and per-byte step of the P6 header parser: signature check,
// comment skipping and the decimal accumulator. Depends on pph_pkg.
`default_nettype none

module pph_parser_core #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step_en,
	input  wire pph_pkg::byte_item_t item,
	output logic                     emit,
	output pph_pkg::hdr_result_t     result
);
	import pph_pkg::*;

	typedef enum logic [2:0] {
		PH_SIG0,
		PH_SIG1,
		PH_SIG2,
		PH_SCAN,
		PH_COMMENT,
		PH_NUMBER,
		PH_DONE
	} phase_t;

	phase_t                  phase_q, ph;
	logic [1:0]              field_q, fi;
	logic [NUM_BITS-1:0]     acc_q, acc, value;
	logic [NUM_BITS-1:0]     width_q, wd;
	logic [NUM_BITS-1:0]     height_q, ht;
	logic [LENGTH_BITS-1:0]  count_q, cnt;
	logic [MAXVAL_BITS-1:0]  maxval;
	logic                    err;
	logic [7:0]              c;

	always_comb begin
		c = item.data_byte;
		ph = item.first_byte ? PH_SIG0 : phase_q;
		fi = item.first_byte ? FIELD_WIDTH : field_q;
		acc = item.first_byte ? '0 : acc_q;
		wd = item.first_byte ? '0 : width_q;
		ht = item.first_byte ? '0 : height_q;
		cnt = item.first_byte ? '0 : count_q;
		value = '0;
		maxval = '0;
		emit = 1'b0;
		err = 1'b0;

		if (ph != PH_DONE) begin
			if (cnt != {LENGTH_BITS{1'b1}}) begin
				cnt = cnt + LENGTH_BITS'(1);
			end
			case (ph)
				PH_SIG0: begin
					if (c != CHAR_P) begin
						emit = 1'b1;
						err = 1'b1;
					end else begin
						ph = PH_SIG1;
					end
				end
				PH_SIG1: begin
					if (c != CHAR_SIX) begin
						emit = 1'b1;
						err = 1'b1;
					end else begin
						ph = PH_SIG2;
					end
				end
				PH_SIG2: begin
					if (!is_space(c)) begin
						emit = 1'b1;
						err = 1'b1;
					end else begin
						ph = PH_SCAN;
					end
				end
				PH_COMMENT: begin
					if (c == CHAR_LF) begin
						ph = PH_SCAN;
					end
				end
				PH_SCAN, PH_NUMBER: begin
					if (is_digit(c)) begin
						acc = acc_step(acc, c);
						ph = PH_NUMBER;
						// Maxval digits running into the last byte still finish the header.
						if (item.last_byte && fi == FIELD_MAXVAL) begin
							maxval = sat_maxval(acc);
							acc = '0;
							fi = FIELD_FULL;
							emit = 1'b1;
						end
					end else begin
						if (ph == PH_NUMBER) begin
							ph = PH_SCAN;
							value = acc;
							acc = '0;
							// A zero width or height leaves the field open for the next number.
							if (fi == FIELD_WIDTH) begin
								if (value != '0) begin
									wd = value;
									fi = FIELD_HEIGHT;
								end
							end else if (fi == FIELD_HEIGHT) begin
								if (value != '0) begin
									ht = value;
									fi = FIELD_MAXVAL;
								end
							end else begin
								maxval = sat_maxval(value);
								fi = FIELD_FULL;
								emit = 1'b1;
							end
						end
						if (!emit && c == CHAR_HASH) begin
							ph = PH_COMMENT;
						end
					end
				end
				default: begin
				end
			endcase
			if (!emit && item.last_byte) begin
				emit = 1'b1;
				err = 1'b1;
			end
			if (emit) begin
				ph = PH_DONE;
			end
		end

		result.error = err;
		result.image_width = err ? '0 : wd;
		result.image_height = err ? '0 : ht;
		result.max_value = err ? '0 : maxval;
		result.header_length = err ? '0 : HDR_LEN_BITS'(cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG0;
			field_q <= FIELD_WIDTH;
			acc_q <= '0;
			width_q <= '0;
			height_q <= '0;
			count_q <= '0;
		end else if (step_en) begin
			phase_q <= ph;
			field_q <= fi;
			acc_q <= acc;
			width_q <= wd;
			height_q <= ht;
			count_q <= cnt;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ppm_p6_header_parser.sv
// Top level of the P6 header parser: input register, parser step and result
// register. Depends on pph_pkg, pph_byte_if, pph_hdr_if and the pph_* modules.
`default_nettype none

// Binary PPM header parser. Bytes of a file arrive one per transfer, with
// first_byte restarting the parser and last_byte closing the file; one byte is
// taken every cycle unless a waiting result stalls it, and the only loop is
// the state update through the multiply-by-ten add of the decimal accumulator.
// Each file yields exactly one result transfer after the byte that decides it:
// the width, height, maxval and header length (counting the byte that ends
// maxval, saturating at 2^LENGTH_BITS - 1 and reported in 16 bits),
// or an error with all fields zero for a bad signature or a file that ends
// before maxval. Bytes after the result are dropped until the next first_byte.
// The result register lets the next byte be taken while a result still waits.
module ppm_p6_header_parser #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	pph_byte_if.sink  bytes,
	pph_hdr_if.source hdr
);
	import pph_pkg::*;

	byte_item_t  in_item, item_s1;
	hdr_result_t res, hdr_q;
	logic        valid_s1, drain, step_en, emit, out_valid_q;

	assign in_item = '{data_byte: bytes.data_byte, first_byte: bytes.first_byte,
		last_byte: bytes.last_byte};

	// A byte may be consumed whenever the result register is empty or emptying.
	assign drain = !out_valid_q || hdr.ready;
	assign step_en = valid_s1 && drain;

	pph_input_stage u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bytes.valid),
		.in_ready (bytes.ready),
		.in_item  (in_item),
		.drain    (drain),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pph_parser_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.emit    (emit),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && emit) begin
			out_valid_q <= 1'b1;
		end else if (hdr.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && emit) begin
			hdr_q <= res;
		end
	end

	assign hdr.valid = out_valid_q;
	assign hdr.error = hdr_q.error;
	assign hdr.image_width = hdr_q.image_width;
	assign hdr.image_height = hdr_q.image_height;
	assign hdr.max_value = hdr_q.max_value;
	assign hdr.header_length = hdr_q.header_length;

`ifndef NO_ASSERTIONS
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && emit |=> out_valid_q)
		else $error("parser result was not captured in the result register");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && hdr_q.error |-> hdr_q.image_width == '0
			&& hdr_q.image_height == '0 && hdr_q.max_value == '0
			&& hdr_q.header_length == '0)
		else $error("error result carries nonzero header fields");

	a_dims_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !hdr_q.error |-> hdr_q.image_width != '0
			&& hdr_q.image_height != '0)
		else $error("header result emitted with width or height unset");
`endif

endmodule

`default_nettype wire
